// ===== sv/lsff_pkg.sv =====
// ----------------------------------------------------------------------------
// lsff_pkg
// Shared types, constants and the sine table generator of the laser scan
// force field block.
// ----------------------------------------------------------------------------
package lsff_pkg;

  // default sizes
  localparam int MaxPointsDef = 1024;
  localparam int AngleBitsDef = 12;

  // datapath widths
  localparam int RangeW   = 16;
  localparam int PctW     = 7;
  localparam int CfgAngW  = 12;
  localparam int TrigW    = 15;
  localparam int MulW     = 17;
  localparam int ProdW    = 34;
  localparam int SumW     = 48;
  localparam int QuotW    = 17;
  localparam int ForceW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam int OneQ14   = 16384;
  localparam int PctScale = 100;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // register reset values
  localparam logic [RangeW-1:0]  MaxRangeRst  = 16'd8000;
  localparam logic [RangeW-1:0]  RepulseRst   = 16'd1500;
  localparam logic [RangeW-1:0]  DepthRst     = 16'd600;
  localparam logic [RangeW-1:0]  WidthRst     = 16'd700;
  localparam logic [PctW-1:0]    PctRst       = 7'd25;
  localparam logic [CfgAngW-1:0] StartRst     = 12'd0;
  localparam logic [CfgAngW-1:0] StepRst      = 12'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_RANGE   = 3'd0,
    CFG_REPULSE     = 3'd1,
    CFG_DEPTH       = 3'd2,
    CFG_WIDTH       = 3'd3,
    CFG_DANGER_PCT  = 3'd4,
    CFG_START_ANGLE = 3'd5,
    CFG_ANGLE_STEP  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_status_t;

  // quarter-wave sine entry k, q14, from a q30 taylor series
  function automatic logic [TrigW-1:0] trig_entry(input int unsigned k,
                                                  input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (64'(k) * HalfPiQ30) >> (abits - 2);
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        default: term = term / 210;
      endcase
      if (n[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (64'(acc) + 64'd32768) >> 16;
    if (v > 64'(OneQ14)) begin
      v = 64'(OneQ14);
    end
    return TrigW'(v);
  endfunction

endpackage

// ===== sv/lsff_trig_rom.sv =====
// ----------------------------------------------------------------------------
// lsff_trig_rom
// Quarter-wave sine table, q14 magnitudes, one registered read port.
// ----------------------------------------------------------------------------
module lsff_trig_rom import lsff_pkg::*; #(
  parameter int AngW = AngleBitsDef
) (
  input  logic                clk_i,
  input  logic [AngW-2:0]     addr_i,
  output logic [TrigW-1:0]    data_o
);

  localparam int Entries = (1 << (AngW - 2)) + 1;

  logic [TrigW-1:0] rom_w [Entries];
  logic [TrigW-1:0] data_q;

  for (genvar k = 0; k < Entries; k++) begin : g_rom
    assign rom_w[k] = trig_entry(k, AngW);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== sv/lsff_div.sv =====
// ----------------------------------------------------------------------------
// lsff_div
// Radix-2 restoring divider for the rounded force average:
// quotient = floor((2*mag + den) / (2*den)), one bit per cycle, with overflow.
// ----------------------------------------------------------------------------
module lsff_div import lsff_pkg::*; #(
  parameter int DenW = 27
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SumW-1:0]    mag_i,
  input  logic [DenW-1:0]    den_i,
  output logic [QuotW-1:0]   quot_o,
  output div_status_t        stat_o
);

  localparam int NumW = SumW + 2;
  localparam int DvsW = DenW + 1;
  localparam int TopW = NumW - QuotW;
  localparam int CntW = $clog2(QuotW + 1);

  logic [NumW-1:0]  num;
  logic [DvsW-1:0]  dvs;
  logic [TopW-1:0]  top;
  logic             ovf_init;
  logic [DvsW:0]    trial;
  logic             fits;

  logic [DvsW-1:0]  rem_q;
  logic [DvsW-1:0]  dvs_q;
  logic [QuotW-1:0] low_q;
  logic [QuotW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             ovf_q;

  assign num      = {mag_i, 1'b0} + NumW'(den_i);
  assign dvs      = {den_i, 1'b0};
  assign top      = num[NumW-1:QuotW];
  assign ovf_init = top >= TopW'(dvs);

  assign trial = {rem_q, low_q[QuotW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DvsW'(top);
      dvs_q  <= dvs;
      low_q  <= num[QuotW-1:0];
      quot_q <= '0;
      ovf_q  <= ovf_init;
    end else if (busy_q) begin
      rem_q  <= fits ? DvsW'(trial - {1'b0, dvs_q}) : DvsW'(trial);
      low_q  <= {low_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], fits};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// ===== sv/laser_scan_force_field.sv =====
// ----------------------------------------------------------------------------
// laser_scan_force_field
// Potential-field force from one laser scan. Points stream in one at a time;
// a valid point passes the sine read, cosine read and accumulate states (sine
// read, cosine read and the two range products share one table port and one
// 17x17 multiplier), an invalid point or one beyond MaxPoints is taken in the
// idle state alone. The end of a scan runs the danger threshold and divisor
// products, then, unless the scan ends in danger or holds no valid point, the
// bit-serial divider for the two averages, and a last state loads the output
// register. The next scan starts while a result still waits on the master side.
// ----------------------------------------------------------------------------
module laser_scan_force_field import lsff_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef,
  parameter int AngleBits = AngleBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [RangeW-1:0]    s_axis_tdata,   // range_mm
  input  logic [0:0]           s_axis_tuser,   // range_valid
  input  logic                 s_axis_tlast,   // last_point
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*ForceW-1:0]  m_axis_tdata,   // forward_force, rotation_force
  output logic [1:0]           m_axis_tuser,   // in_danger, no_valid_points
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int CntW    = $clog2(MaxPoints + 1);
  localparam int AngW    = AngleBits;
  localparam int Quarter = 1 << (AngW - 2);
  localparam int RomAw   = AngW - 1;
  localparam int DenW    = RangeW + CntW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SIN    = 10'b0000000010,
    S_COS    = 10'b0000000100,
    S_ACC    = 10'b0000001000,
    S_THR    = 10'b0000010000,
    S_DEN    = 10'b0000100000,
    S_DECIDE = 10'b0001000000,
    S_DIVX   = 10'b0010000000,
    S_DIVY   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  function automatic logic [RomAw-1:0] quad_addr(input logic [AngW-1:0] ang);
    logic [RomAw-1:0] low;
    low = RomAw'(ang[AngW-3:0]);
    return ang[AngW-2] ? RomAw'(Quarter) - low : low;
  endfunction

  function automatic logic signed [ForceW-1:0] clip_force(input logic neg,
                                                         input logic ovf,
                                                         input logic [QuotW-1:0] q);
    logic signed [ForceW-1:0] res;
    if (neg) begin
      res = (ovf || q > QuotW'(32768)) ? 16'sh8000 : ForceW'(QuotW'(0) - q);
    end else begin
      res = (ovf || q > QuotW'(OneQ14)) ? ForceW'(OneQ14) : ForceW'(q);
    end
    return res;
  endfunction

  state_e state_q, state_d;

  logic [RangeW-1:0]  max_range_q, repulse_q, depth_q, width_q;
  logic [PctW-1:0]    pct_q;
  logic [CfgAngW-1:0] start_q, step_q;

  logic [CntW-1:0]        pc_q, vc_q, dc_q;
  logic signed [SumW-1:0] sum_x_q, sum_y_q;
  logic                   danger_act_q, held_neg_q, danger_q;
  logic [AngW-1:0]        ang_q, pt_ang_q;
  logic [RangeW-1:0]      r_q;
  logic                   last_q;
  logic signed [ProdW-1:0] prod_q, py_q;
  logic [DenW-1:0]        den_q;
  logic signed [ForceW-1:0] fwd_q, rot_q;
  logic                   out_valid_q;
  logic [2*ForceW-1:0]    out_data_q;
  logic [1:0]             out_user_q;

  logic [RangeW-1:0]  range_lim, range_clip;
  logic               in_fire, pt_take, out_free;
  logic [AngW-1:0]    cur_ang, cos_ang, trig_ang;
  logic [RomAw-1:0]   rom_addr;
  logic [TrigW-1:0]   rom_data;
  logic signed [MulW-1:0]  trig_val, mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [ProdW-1:0]   py_abs, thr_lim;
  logic               near, in_box, danger_now, no_valid;
  logic signed [SumW-1:0] px_ext, py_ext, step_x, step_y;
  logic               div_start;
  logic [SumW-1:0]    div_mag;
  logic [DenW-1:0]    div_den;
  logic [QuotW-1:0]   div_quot;
  div_status_t        div_st;
  logic signed [ForceW-1:0] fwd_out, rot_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= MaxRangeRst;
      repulse_q   <= RepulseRst;
      depth_q     <= DepthRst;
      width_q     <= WidthRst;
      pct_q       <= PctRst;
      start_q     <= StartRst;
      step_q      <= StepRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_RANGE:   max_range_q <= cfg_data_i;
        CFG_REPULSE:     repulse_q   <= cfg_data_i;
        CFG_DEPTH:       depth_q     <= cfg_data_i;
        CFG_WIDTH:       width_q     <= cfg_data_i;
        CFG_DANGER_PCT:  pct_q       <= cfg_data_i[PctW-1:0];
        CFG_START_ANGLE: start_q     <= cfg_data_i[CfgAngW-1:0];
        CFG_ANGLE_STEP:  step_q      <= cfg_data_i[CfgAngW-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign s_axis_tready = state_q == S_IDLE;
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign pt_take    = pc_q < CntW'(MaxPoints);
  assign range_lim  = (max_range_q == '0) ? RangeW'(1) : max_range_q;
  assign range_clip = (s_axis_tdata > range_lim) ? range_lim : s_axis_tdata;
  assign cur_ang    = (pc_q == '0) ? AngW'(start_q) : ang_q;
  assign cos_ang    = pt_ang_q + AngW'(Quarter);

  // sine table
  assign rom_addr = (state_q == S_SIN) ? quad_addr(cos_ang) : quad_addr(cur_ang);

  lsff_trig_rom #(
    .AngW (AngW)
  ) u_trig_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign trig_ang = (state_q == S_COS) ? cos_ang : pt_ang_q;
  assign trig_val = trig_ang[AngW-1] ? -$signed({2'b00, rom_data})
                                     : $signed({2'b00, rom_data});

  // shared multiplier
  always_comb begin
    mul_a = $signed({1'b0, r_q});
    mul_b = trig_val;
    case (state_q)
      S_THR: begin
        mul_a = $signed(MulW'(pc_q));
        mul_b = $signed(MulW'(pct_q));
      end
      S_DEN: begin
        mul_a = $signed({1'b0, range_lim});
        mul_b = $signed(MulW'(vc_q));
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // per-point classification and contribution
  assign py_abs = py_q[ProdW-1] ? ProdW'(-py_q) : ProdW'(py_q);
  assign near   = r_q < repulse_q;
  assign in_box = (prod_q < $signed(ProdW'({depth_q, 14'd0}))) &&
                  (py_abs < ProdW'({width_q, 13'd0}));
  assign px_ext = SumW'(prod_q);
  assign py_ext = SumW'(py_q);
  assign step_x = !near ? px_ext : (in_box ? -(px_ext <<< 1) : -px_ext);
  assign step_y = !near ? py_ext : (in_box ? -(py_ext <<< 1) : -py_ext);

  // end of scan
  assign thr_lim    = ProdW'(dc_q) * ProdW'(PctScale) + ProdW'(PctScale);
  assign danger_now = $unsigned(prod_q) < thr_lim;
  assign no_valid   = vc_q == '0;

  assign div_start = ((state_q == S_DECIDE) && !danger_q && !no_valid) ||
                     ((state_q == S_DIVX) && div_st.done);
  assign div_mag   = (state_q == S_DIVX)
                   ? (sum_y_q[SumW-1] ? SumW'(-sum_y_q) : SumW'(sum_y_q))
                   : (sum_x_q[SumW-1] ? SumW'(-sum_x_q) : SumW'(sum_x_q));
  assign div_den   = (state_q == S_DIVX) ? den_q : prod_q[DenW-1:0];

  lsff_div #(
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_st)
  );

  always_comb begin
    if (danger_q) begin
      fwd_out = '0;
      rot_out = held_neg_q ? -ForceW'(OneQ14) : ForceW'(OneQ14);
    end else if (no_valid) begin
      fwd_out = '0;
      rot_out = '0;
    end else begin
      fwd_out = fwd_q;
      rot_out = rot_q;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (pt_take && s_axis_tuser[0]) begin
            state_d = S_SIN;
          end else if (s_axis_tlast) begin
            state_d = S_THR;
          end
        end
      end
      S_SIN:    state_d = S_COS;
      S_COS:    state_d = S_ACC;
      S_ACC:    state_d = last_q ? S_THR : S_IDLE;
      S_THR:    state_d = S_DEN;
      S_DEN:    state_d = S_DECIDE;
      S_DECIDE: state_d = (danger_q || no_valid) ? S_OUT : S_DIVX;
      S_DIVX: begin
        if (div_st.done) begin
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_st.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= '0;
      vc_q         <= '0;
      dc_q         <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      ang_q        <= '0;
      danger_act_q <= 1'b0;
      held_neg_q   <= 1'b0;
      danger_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && pt_take) begin
        pc_q  <= pc_q + 1'b1;
        ang_q <= cur_ang + AngW'(step_q);
        if (s_axis_tuser[0]) begin
          vc_q <= vc_q + 1'b1;
        end
      end
      if (state_q == S_ACC) begin
        sum_x_q <= sum_x_q + step_x;
        sum_y_q <= sum_y_q + step_y;
        if (near && in_box) begin
          dc_q <= dc_q + 1'b1;
        end
      end
      if (state_q == S_DEN) begin
        danger_q <= danger_now;
        if (danger_now) begin
          if (!danger_act_q) begin
            held_neg_q <= sum_y_q[SumW-1];
          end
          danger_act_q <= 1'b1;
        end else begin
          danger_act_q <= 1'b0;
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
        pc_q        <= '0;
        vc_q        <= '0;
        dc_q        <= '0;
        sum_x_q     <= '0;
        sum_y_q     <= '0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_q    <= range_clip;
      last_q <= s_axis_tlast;
      if (pt_take) begin
        pt_ang_q <= cur_ang;
      end
    end
    if (state_q == S_COS) begin
      py_q <= prod_q;
    end
    if (state_q == S_DECIDE) begin
      den_q <= prod_q[DenW-1:0];
    end
    if ((state_q == S_DIVX) && div_st.done) begin
      fwd_q <= clip_force(sum_x_q[SumW-1], div_st.ovf, div_quot);
    end
    if ((state_q == S_DIVY) && div_st.done) begin
      rot_q <= clip_force(sum_y_q[SumW-1], div_st.ovf, div_quot);
    end
    if ((state_q == S_OUT) && out_free) begin
      out_data_q <= {rot_out, fwd_out};
      out_user_q <= {no_valid, danger_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIVX || state_q == S_DIVY))
    else $error("divider running outside the averaging states");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result raised outside the final state");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dc_q <= vc_q) && (vc_q <= pc_q) && (pc_q <= CntW'(MaxPoints)))
    else $error("scan counters out of order");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for laser_scan_force_field. Laser scans are queued as
// streams of range points; every accepted point is folded into a bit-exact
// model of the force accumulation, and each end-of-scan force result is
// compared field by field on the output stream. Register settings, including
// the extremes, change between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb import lsff_pkg::*; ();

  localparam int MaxPts    = 1024;
  localparam int Quarter   = 1024;
  localparam int TurnMask  = 4095;
  localparam int UnitQ14   = 16384;

  typedef enum int {SCAN_MIXED, SCAN_NEAR, SCAN_BLANK} scan_kind_e;

  typedef struct {
    logic [RangeW-1:0] range_mm;
    logic              range_ok;
    logic              last_pt;
  } scan_point_t;

  typedef struct {
    logic signed [ForceW-1:0] fwd;
    logic signed [ForceW-1:0] rot;
    logic                     danger;
    logic                     empty;
  } force_out_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [RangeW-1:0]     s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*ForceW-1:0]   m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;

  // register copies
  int rg_max_range, rg_repulse, rg_depth, rg_width, rg_pct, rg_start, rg_step;

  // scan accumulation state
  int          n_pts, n_valid, n_danger;
  longint      acc_x, acc_y;
  bit          danger_latched, turn_neg;
  logic [14:0] sine_lut [0:Quarter];

  scan_point_t points_due[$];
  force_out_t  forces_due[$];
  scan_point_t pt;
  force_out_t  want;

  int in_sent_cnt, in_acc_cnt, res_cnt, err_cnt;
  int src_idle_pct, snk_idle_pct;
  int hold_at, hold_left;
  bit hold_arm, hold_done;

  always #5 clk_i = ~clk_i;

  laser_scan_force_field i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic void build_sine_lut();
    longint unsigned x, term, v;
    longint          acc;
    for (int k = 0; k <= Quarter; k++) begin
      x    = (longint'(k) * HalfPiQ30) >> 10;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (longint'(acc) + 32768) >> 16;
      if (v > UnitQ14) begin
        v = UnitQ14;
      end
      sine_lut[k] = v[14:0];
    end
  endfunction

  function automatic longint sin_q14(int ang);
    int     quad, r;
    longint v;
    ang  = ang & TurnMask;
    quad = ang >> 10;
    r    = ang & (Quarter - 1);
    v    = (quad % 2 == 1) ? longint'(sine_lut[Quarter - r]) : longint'(sine_lut[r]);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic logic signed [ForceW-1:0] avg_q14(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    if (q > 40000) begin
      q = 40000;
    end
    if (num < 0) begin
      q = -q;
    end
    if (q > UnitQ14) begin
      q = UnitQ14;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return ForceW'(q);
  endfunction

  // fold one accepted point into the scan sums, queue the force on scan end
  function automatic void fold_point(logic [RangeW-1:0] range_mm, logic ok, logic last_pt);
    longint     m, c, s, r, f, px, py, thr;
    int         ang;
    force_out_t res;
    m = (rg_max_range == 0) ? 1 : rg_max_range;
    if (n_pts < MaxPts) begin
      ang = (rg_start + n_pts * rg_step) & TurnMask;
      n_pts++;
      if (ok) begin
        c = sin_q14(ang + Quarter);
        s = sin_q14(ang);
        r = (longint'(range_mm) > m) ? m : longint'(range_mm);
        f = r;
        n_valid++;
        if (r < rg_repulse) begin
          px = r * c;
          py = r * s;
          if (py < 0) begin
            py = -py;
          end
          if (px < longint'(rg_depth) * UnitQ14 && 2 * py < longint'(rg_width) * UnitQ14) begin
            n_danger++;
            f = -2 * r;
          end else begin
            f = -r;
          end
        end
        acc_x += f * c;
        acc_y += f * s;
      end
    end
    if (last_pt) begin
      thr        = (longint'(n_pts) * rg_pct) / 100;
      res.danger = (n_danger >= thr);
      res.empty  = (n_valid == 0);
      if (res.danger) begin
        res.fwd = '0;
        if (!danger_latched) begin
          turn_neg = (acc_y < 0);
        end
        res.rot        = turn_neg ? -16'sd16384 : 16'sd16384;
        danger_latched = 1'b1;
      end else begin
        danger_latched = 1'b0;
        if (n_valid == 0) begin
          res.fwd = '0;
          res.rot = '0;
        end else begin
          res.fwd = avg_q14(acc_x, m * n_valid);
          res.rot = avg_q14(acc_y, m * n_valid);
        end
      end
      forces_due.insert(forces_due.size(), res);
      n_pts    = 0;
      n_valid  = 0;
      n_danger = 0;
      acc_x    = 0;
      acc_y    = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("tb: mismatch in %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
    err_cnt++;
  endtask

  // sample both streams at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        res_cnt++;
        if (forces_due.size() == 0) begin
          report_mismatch("unexpected result", longint'(m_axis_tdata), 0);
        end else begin
          want = forces_due.pop_front();
          if ($signed(m_axis_tdata[ForceW-1:0]) != want.fwd) begin
            report_mismatch("forward_force", $signed(m_axis_tdata[ForceW-1:0]), want.fwd);
          end
          if ($signed(m_axis_tdata[2*ForceW-1:ForceW]) != want.rot) begin
            report_mismatch("rotation_force", $signed(m_axis_tdata[2*ForceW-1:ForceW]),
                            want.rot);
          end
          if (m_axis_tuser[0] != want.danger) begin
            report_mismatch("in_danger", m_axis_tuser[0], want.danger);
          end
          if (m_axis_tuser[1] != want.empty) begin
            report_mismatch("no_valid_points", m_axis_tuser[1], want.empty);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_acc_cnt++;
        fold_point(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
      end
    end
  end

  // point driver
  always @(negedge clk_i) begin
    if (rst_ni && in_acc_cnt == in_sent_cnt) begin
      if (points_due.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        pt = points_due.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pt.range_mm;
        s_axis_tuser  <= pt.range_ok;
        s_axis_tlast  <= pt.last_pt;
        in_sent_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk_i) begin
    if (hold_arm && !hold_done && res_cnt >= hold_at) begin
      hold_left = 500;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic add_point(int range_mm, bit ok, bit last_pt);
    scan_point_t p;
    p.range_mm = RangeW'(range_mm);
    p.range_ok = ok;
    p.last_pt  = last_pt;
    points_due.insert(points_due.size(), p);
  endtask

  function automatic int pick_range(scan_kind_e kind);
    int near_hi, sel;
    near_hi = (rg_repulse > 0) ? rg_repulse - 1 : 0;
    sel     = $urandom_range(99);
    if ((kind == SCAN_NEAR && sel < 80) || sel < 30) begin
      return $urandom_range(near_hi, 0);
    end
    if (sel < 40) begin
      case ($urandom_range(3))
        0:       return 0;
        1:       return 65535;
        2:       return rg_max_range;
        default: return rg_repulse;
      endcase
    end
    if (sel < 70) begin
      return $urandom_range(65535, 0);
    end
    return $urandom_range(rg_max_range, 0);
  endfunction

  task automatic add_scan(int len, scan_kind_e kind);
    for (int i = 0; i < len; i++) begin
      add_point(pick_range(kind), kind != SCAN_BLANK && $urandom_range(99) < 85, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    while (points_due.size() != 0 || in_acc_cnt != in_sent_cnt || forces_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
  endtask

  // one register write transaction
  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      CFG_MAX_RANGE:   rg_max_range = val & 16'hffff;
      CFG_REPULSE:     rg_repulse   = val & 16'hffff;
      CFG_DEPTH:       rg_depth     = val & 16'hffff;
      CFG_WIDTH:       rg_width     = val & 16'hffff;
      CFG_DANGER_PCT:  rg_pct       = val & 7'h7f;
      CFG_START_ANGLE: rg_start     = val & 12'hfff;
      CFG_ANGLE_STEP:  rg_step      = val & 12'hfff;
      default: ;
    endcase
  endtask

  task automatic program_regs(int mx, int rep, int dep, int wid, int pct, int st, int stp);
    write_reg(CFG_MAX_RANGE, mx);
    write_reg(CFG_REPULSE, rep);
    write_reg(CFG_DEPTH, dep);
    write_reg(CFG_WIDTH, wid);
    write_reg(CFG_DANGER_PCT, pct);
    write_reg(CFG_START_ANGLE, st);
    write_reg(CFG_ANGLE_STEP, stp);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int budget, len, pick;
    build_sine_lut();
    rg_max_range = 8000;
    rg_repulse   = 1500;
    rg_depth     = 600;
    rg_width     = 700;
    rg_pct       = 25;
    rg_start     = 0;
    rg_step      = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero range, lone invalid point, clamped and repulsive mix
    add_point(0, 1, 1);
    add_point(1000, 0, 1);
    add_point(65535, 1, 0);
    add_point(0, 0, 0);
    add_point(9000, 1, 0);
    add_point(700, 1, 1);
    wait_idle();

    // quarter-turn steps from the rear, all points must be in danger
    write_reg(CFG_DANGER_PCT, 100);
    write_reg(CFG_START_ANGLE, 2048);
    write_reg(CFG_ANGLE_STEP, 1024);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    add_point(65535, 1, 0);
    add_point(8000, 1, 0);
    add_point(1499, 1, 0);
    add_point(300, 1, 1);
    add_point(5, 0, 0);
    add_point(65535, 0, 1);
    add_point(100, 1, 0);
    add_point(100, 1, 0);
    add_point(100, 1, 0);
    add_point(300, 1, 1);
    add_point(100, 1, 1);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 8;
          snk_idle_pct = 87;
        end
        1: begin
          src_idle_pct = 87;
          snk_idle_pct = 8;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 2; k++) begin
        case (ph * 2 + k)
          0: program_regs(8000, 1500, 600, 700, 25, 0, 3);
          1: program_regs(65535, 65535, 65535, 65535, 100, 4095, 4095);
          2: program_regs(0, 0, 0, 0, 0, 0, 0);
          3: program_regs($urandom_range(65535, 1), $urandom_range(65535, 0),
                          $urandom_range(65535, 0), $urandom_range(65535, 0),
                          $urandom_range(100, 0), $urandom_range(4095, 0),
                          $urandom_range(4095, 0));
          4: program_regs(2000, 1200, 800, 1500, 50, 3900, 17);
          default: program_regs($urandom_range(20000, 100), $urandom_range(3000, 0),
                                $urandom_range(3000, 0), $urandom_range(6000, 0), 127,
                                $urandom_range(4095, 0), $urandom_range(4095, 0));
        endcase
        if (ph == 2 && k == 0) begin
          hold_at  = res_cnt + 2;
          hold_arm = 1'b1;
        end
        budget = 130;
        while (budget > 0) begin
          len  = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
          pick = $urandom_range(9);
          if (pick == 0) begin
            add_scan(len, SCAN_BLANK);
          end else if (pick < 4) begin
            add_scan(len, SCAN_NEAR);
          end else begin
            add_scan(len, SCAN_MIXED);
          end
          budget -= len;
        end
        // scan longer than the point limit
        if (ph == 2 && k == 1) begin
          add_scan($urandom_range(1080, 1040), SCAN_MIXED);
          add_scan(3, SCAN_NEAR);
        end
        wait_idle();
      end
    end

    if (err_cnt == 0 && forces_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lsff_pkg.sv
sv/lsff_trig_rom.sv
sv/lsff_div.sv
sv/laser_scan_force_field.sv
bench/tb.sv
